// ----- sv/jts_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jts_pkg
// Types, codes and helper functions shared by the JSON token scanner.
// ----------------------------------------------------------------------------
package jts_pkg;

  typedef enum logic [3:0] {
    MODE_START = 4'd0,
    MODE_INT   = 4'd1,
    MODE_REAL  = 4'd2,
    MODE_STR   = 4'd3,
    MODE_ESC   = 4'd4,
    MODE_TRUE  = 4'd5,
    MODE_FALSE = 4'd6,
    MODE_NULL  = 4'd7
  } mode_t;

  typedef enum logic [3:0] {
    TOK_EOS    = 4'd0,
    TOK_LBRACE = 4'd1,
    TOK_RBRACE = 4'd2,
    TOK_LBRACK = 4'd3,
    TOK_RBRACK = 4'd4,
    TOK_COMMA  = 4'd5,
    TOK_COLON  = 4'd6,
    TOK_INT    = 4'd7,
    TOK_REAL   = 4'd8,
    TOK_BOOL   = 4'd9,
    TOK_STRING = 4'd10,
    TOK_NULL   = 4'd11
  } tok_t;

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_SYNTAX = 3'd1,
    ERR_NUMBER = 3'd2,
    ERR_BOOL   = 3'd3,
    ERR_NULL   = 3'd4,
    ERR_STRING = 3'd5
  } err_t;

  typedef struct packed {
    logic       text_valid;
    logic [7:0] text_char;
    logic       token_done;
    tok_t       token_type;
    err_t       error_code;
    logic       last;
  } res_t;

  typedef struct packed {
    logic       emit;
    res_t       res;
    mode_t      mode;
    logic [2:0] pos;
  } start_t;

  localparam logic [7:0] CH_NUL = 8'h00;

  function automatic res_t mk_res(logic tv, logic [7:0] ch, logic dn, tok_t ty, err_t e);
    res_t r;
    r.text_valid = tv;
    r.text_char  = tv ? ch : 8'h00;
    r.token_done = dn;
    r.token_type = dn ? ty : TOK_EOS;
    r.error_code = e;
    r.last       = 1'b0;
    return r;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic start_t start_token(logic [7:0] c);
    start_t s;
    s.emit = 1'b1;
    s.mode = MODE_START;
    s.pos  = 3'd0;
    s.res  = mk_res(1'b0, c, 1'b0, TOK_EOS, ERR_NONE);
    if (c inside {8'h0A, 8'h0D, 8'h09, 8'h20}) begin
      s.emit = 1'b0;
    end else begin
      case (c)
        CH_NUL: s.res = mk_res(1'b0, c, 1'b1, TOK_EOS, ERR_NONE);
        "{":    s.res = mk_res(1'b1, c, 1'b1, TOK_LBRACE, ERR_NONE);
        "}":    s.res = mk_res(1'b1, c, 1'b1, TOK_RBRACE, ERR_NONE);
        "[":    s.res = mk_res(1'b1, c, 1'b1, TOK_LBRACK, ERR_NONE);
        "]":    s.res = mk_res(1'b1, c, 1'b1, TOK_RBRACK, ERR_NONE);
        ",":    s.res = mk_res(1'b1, c, 1'b1, TOK_COMMA, ERR_NONE);
        ":":    s.res = mk_res(1'b1, c, 1'b1, TOK_COLON, ERR_NONE);
        "\"": begin
          s.emit = 1'b0;
          s.mode = MODE_STR;
        end
        ".": begin
          s.res  = mk_res(1'b1, c, 1'b0, TOK_EOS, ERR_NONE);
          s.mode = MODE_REAL;
        end
        "t", "f", "n": begin
          s.res  = mk_res(1'b1, c, 1'b0, TOK_EOS, ERR_NONE);
          s.mode = (c == "t") ? MODE_TRUE : ((c == "f") ? MODE_FALSE : MODE_NULL);
          s.pos  = 3'd1;
        end
        default: begin
          if ((c == "-") || is_digit(c)) begin
            s.res  = mk_res(1'b1, c, 1'b0, TOK_EOS, ERR_NONE);
            s.mode = MODE_INT;
          end else begin
            s.res = mk_res(1'b0, c, 1'b0, TOK_EOS, ERR_SYNTAX);
          end
        end
      endcase
    end
    return s;
  endfunction

  function automatic logic [2:0] word_len(mode_t m);
    return (m == MODE_FALSE) ? 3'd5 : 3'd4;
  endfunction

  function automatic logic [7:0] word_char(mode_t m, logic [2:0] p);
    logic [7:0] ch;
    ch = 8'h00;
    case (m)
      MODE_TRUE: begin
        case (p)
          3'd0:    ch = "t";
          3'd1:    ch = "r";
          3'd2:    ch = "u";
          3'd3:    ch = "e";
          default: ch = 8'h00;
        endcase
      end
      MODE_FALSE: begin
        case (p)
          3'd0:    ch = "f";
          3'd1:    ch = "a";
          3'd2:    ch = "l";
          3'd3:    ch = "s";
          3'd4:    ch = "e";
          default: ch = 8'h00;
        endcase
      end
      default: begin
        case (p)
          3'd0:    ch = "n";
          3'd1:    ch = "u";
          3'd2:    ch = "l";
          3'd3:    ch = "l";
          default: ch = 8'h00;
        endcase
      end
    endcase
    return ch;
  endfunction

endpackage

// ----- sv/jts_lexer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jts_lexer
// Scan state and per-character transition; yields up to two results a step.
// ----------------------------------------------------------------------------
module jts_lexer (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step_en,
  input  logic [7:0]    char_in,
  output logic [1:0]    res_cnt,
  output jts_pkg::res_t res0,
  output jts_pkg::res_t res1
);

  jts_pkg::mode_t  mode_r, mode_nxt;
  logic [2:0]      pos_r, pos_nxt;
  jts_pkg::start_t st;
  logic            term;
  logic            word_hit;
  logic [2:0]      wlen;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= jts_pkg::MODE_START;
      pos_r  <= 3'd0;
    end else if (step_en) begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
    end
  end

  always_comb begin
    st       = jts_pkg::start_token(char_in);
    term     = (char_in inside {8'h0A, 8'h0D, 8'h09, 8'h20, 8'h00, ",", "}", "]"});
    wlen     = jts_pkg::word_len(mode_r);
    word_hit = (pos_r < wlen) && (char_in == jts_pkg::word_char(mode_r, pos_r));
    mode_nxt = mode_r;
    pos_nxt  = pos_r;
    res_cnt  = 2'd0;
    res0     = '0;
    res1     = '0;
    case (mode_r)
      jts_pkg::MODE_INT, jts_pkg::MODE_REAL: begin
        if (term) begin
          res0 = jts_pkg::mk_res(1'b0, char_in, 1'b1,
                   (mode_r == jts_pkg::MODE_INT) ? jts_pkg::TOK_INT : jts_pkg::TOK_REAL,
                   jts_pkg::ERR_NONE);
          mode_nxt = st.mode;
          pos_nxt  = st.pos;
          res1     = st.res;
          res_cnt  = st.emit ? 2'd2 : 2'd1;
        end else if (jts_pkg::is_digit(char_in)) begin
          res0    = jts_pkg::mk_res(1'b1, char_in, 1'b0, jts_pkg::TOK_EOS, jts_pkg::ERR_NONE);
          res_cnt = 2'd1;
        end else if ((char_in == ".") && (mode_r == jts_pkg::MODE_INT)) begin
          res0     = jts_pkg::mk_res(1'b1, char_in, 1'b0, jts_pkg::TOK_EOS, jts_pkg::ERR_NONE);
          res_cnt  = 2'd1;
          mode_nxt = jts_pkg::MODE_REAL;
        end else begin
          res0     = jts_pkg::mk_res(1'b0, char_in, 1'b0, jts_pkg::TOK_EOS, jts_pkg::ERR_NUMBER);
          res_cnt  = 2'd1;
          mode_nxt = jts_pkg::MODE_START;
          pos_nxt  = 3'd0;
        end
      end
      jts_pkg::MODE_STR: begin
        res_cnt = 2'd1;
        if (char_in == jts_pkg::CH_NUL) begin
          res0     = jts_pkg::mk_res(1'b0, char_in, 1'b0, jts_pkg::TOK_EOS, jts_pkg::ERR_STRING);
          mode_nxt = jts_pkg::MODE_START;
          pos_nxt  = 3'd0;
        end else if (char_in == "\"") begin
          res0     = jts_pkg::mk_res(1'b0, char_in, 1'b1, jts_pkg::TOK_STRING, jts_pkg::ERR_NONE);
          mode_nxt = jts_pkg::MODE_START;
        end else begin
          res0 = jts_pkg::mk_res(1'b1, char_in, 1'b0, jts_pkg::TOK_EOS, jts_pkg::ERR_NONE);
          if (char_in == "\\") begin
            mode_nxt = jts_pkg::MODE_ESC;
          end
        end
      end
      jts_pkg::MODE_ESC: begin
        res_cnt = 2'd1;
        if (char_in inside {"\"", "\\", "/", "b", "f", "n", "r", "t", "u"}) begin
          res0     = jts_pkg::mk_res(1'b1, char_in, 1'b0, jts_pkg::TOK_EOS, jts_pkg::ERR_NONE);
          mode_nxt = jts_pkg::MODE_STR;
        end else begin
          res0     = jts_pkg::mk_res(1'b0, char_in, 1'b0, jts_pkg::TOK_EOS, jts_pkg::ERR_STRING);
          mode_nxt = jts_pkg::MODE_START;
          pos_nxt  = 3'd0;
        end
      end
      jts_pkg::MODE_TRUE, jts_pkg::MODE_FALSE, jts_pkg::MODE_NULL: begin
        res_cnt = 2'd1;
        if (!word_hit) begin
          res0 = jts_pkg::mk_res(1'b0, char_in, 1'b0, jts_pkg::TOK_EOS,
                   (mode_r == jts_pkg::MODE_NULL) ? jts_pkg::ERR_NULL : jts_pkg::ERR_BOOL);
          mode_nxt = jts_pkg::MODE_START;
          pos_nxt  = 3'd0;
        end else if (pos_r + 3'd1 == wlen) begin
          res0 = jts_pkg::mk_res(1'b1, char_in, 1'b1,
                   (mode_r == jts_pkg::MODE_NULL) ? jts_pkg::TOK_NULL : jts_pkg::TOK_BOOL,
                   jts_pkg::ERR_NONE);
          mode_nxt = jts_pkg::MODE_START;
          pos_nxt  = 3'd0;
        end else begin
          res0    = jts_pkg::mk_res(1'b1, char_in, 1'b0, jts_pkg::TOK_EOS, jts_pkg::ERR_NONE);
          pos_nxt = pos_r + 3'd1;
        end
      end
      default: begin
        mode_nxt = st.mode;
        pos_nxt  = st.pos;
        res0     = st.res;
        res_cnt  = st.emit ? 2'd1 : 2'd0;
      end
    endcase
    if (res_cnt == 2'd1) begin
      res0.last = 1'b1;
    end else if (res_cnt == 2'd2) begin
      res1.last = 1'b1;
    end
  end

  a_pos_words_only: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != jts_pkg::MODE_TRUE && mode_r != jts_pkg::MODE_FALSE &&
     mode_r != jts_pkg::MODE_NULL) |-> pos_r == 3'd0)
    else $error("letter position set outside a word");

  a_error_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && res_cnt != 2'd0 && res0.error_code != jts_pkg::ERR_NONE)
    |=> (mode_r == jts_pkg::MODE_START && pos_r == 3'd0))
    else $error("scanner did not return to start after an error");

  a_pair_is_number_end: assert property (@(posedge clk) disable iff (!rst_n)
    (res_cnt == 2'd2) |-> (res0.token_done && !res0.text_valid &&
     (res0.token_type == jts_pkg::TOK_INT || res0.token_type == jts_pkg::TOK_REAL)))
    else $error("two results without a number end");

endmodule

// ----- sv/jts_out_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jts_out_fifo
// Four-entry result queue: up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
module jts_out_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    push_cnt,
  input  jts_pkg::res_t push0,
  input  jts_pkg::res_t push1,
  output logic          room,
  output logic          out_valid,
  input  logic          out_stall,
  output jts_pkg::res_t out_res
);

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);

  jts_pkg::res_t   mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PtrW:0]   count_r, count_nxt;
  logic            pop;

  assign out_valid = (count_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign room      = (count_r <= (PtrW+1)'(Depth - 2));
  assign count_nxt = count_r + (PtrW+1)'(push_cnt) - (PtrW+1)'(pop);

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wr_ptr_r + PtrW'(1)] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PtrW'(push_cnt);
      rd_ptr_r <= rd_ptr_r + PtrW'(pop);
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (PtrW+1)'(Depth))
    else $error("result queue overfilled");

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push_cnt != 2'd0) |-> room)
    else $error("result pushed without room");

endmodule

// ----- sv/json_token_scanner.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_token_scanner
// Streaming JSON lexer, one character per input beat.
// ----------------------------------------------------------------------------
// Each character beat is taken into an input register, scanned there, and its
// zero, one or two result beats go into a four-entry result queue. A new
// character is taken every cycle while the queue has room for two results;
// characters then pass through the result queue to the result port. Sustained
// rate is one character per cycle while each causes at most one result and the
// output is not stalled; the port moves one beat per unstalled cycle, so
// a character that ends a number and starts a punctuator gives two results.
// ----------------------------------------------------------------------------
module json_token_scanner (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_text_valid,
  output logic [7:0] out_text_char,
  output logic       out_token_done,
  output logic [3:0] out_token_type,
  output logic [2:0] out_error_code,
  output logic       out_last
);

  logic          hold_v_r, hold_v_nxt;
  logic [7:0]    hold_char_r;
  logic          room;
  logic          step_en;
  logic [1:0]    res_cnt;
  jts_pkg::res_t res0, res1, out_res;

  assign step_en  = hold_v_r && room;
  assign in_stall = hold_v_r && !room;

  always_comb begin
    hold_v_nxt = hold_v_r;
    if (in_valid && !in_stall) begin
      hold_v_nxt = 1'b1;
    end else if (step_en) begin
      hold_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_char_r <= in_char_in;
    end
  end

  jts_lexer u_lexer (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .char_in (hold_char_r),
    .res_cnt (res_cnt),
    .res0    (res0),
    .res1    (res1)
  );

  jts_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (step_en ? res_cnt : 2'd0),
    .push0     (res0),
    .push1     (res1),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_text_valid = out_res.text_valid;
  assign out_text_char  = out_res.text_char;
  assign out_token_done = out_res.token_done;
  assign out_token_type = out_res.token_type;
  assign out_error_code = out_res.error_code;
  assign out_last       = out_res.last;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (hold_v_r && !room))
    else $error("input stalled with room in queue");

  a_held_beat_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (hold_v_r && room) |=> (!hold_v_r || $past(in_valid)))
    else $error("held character beat not consumed");

  a_idle_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    !hold_v_r |-> !step_en)
    else $error("scanner stepped without a character");

endmodule
